### rtl/pmc_pkg.sv
// Shared types, codes and constants of the positioner motor controller.
`default_nettype none

package pmc_pkg;

    // Default widths for the top-level parameters.
    localparam int DUTY_BITS_DEF = 10;
    localparam int TIME_BITS_DEF = 32;

    // Fixed field widths.
    localparam int PCT_BITS      = 7;
    localparam int POS_BITS      = 10;
    localparam int CFG_ADDR_BITS = 3;

    // Full scale of a percentage.
    localparam logic [PCT_BITS-1:0] PCT_FULL = 7'd100;

    // Register reset values.
    localparam logic [PCT_BITS-1:0] TARGET_RESET    = 7'd25;
    localparam logic [PCT_BITS-1:0] DEAD_BAND_RESET = 7'd2;
    localparam int                  MIN_DUTY_RESET  = 300;
    localparam int                  MAX_DUTY_RESET  = 1023;
    localparam int                  TIMEOUT_RESET   = 10000;

    // Configuration register indexes.
    typedef enum logic [CFG_ADDR_BITS-1:0] {
        CFG_TARGET    = 3'd0,
        CFG_DEAD_BAND = 3'd1,
        CFG_MIN_DUTY  = 3'd2,
        CFG_MAX_DUTY  = 3'd3,
        CFG_TIMEOUT   = 3'd4
    } cfg_reg_t;

    // Direction of the active move.
    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd2
    } dir_t;

    // Latched fault code as reported on the result.
    typedef enum logic [1:0] {
        FAULT_NONE     = 2'd0,
        FAULT_FEEDBACK = 2'd1,
        FAULT_TIMEOUT  = 2'd2
    } fault_t;

    // Bridge and status flags of one result.
    typedef struct packed {
        logic   moving;
        fault_t fault;
        logic   drive_reverse;
        logic   drive_forward;
    } res_flags_t;

endpackage

`default_nettype wire

### rtl/positioner_motor_controller_top.sv
// Top level of the positioner motor controller: stream ports and request registers.
`default_nettype none

// Proportional positioner controller. Each request on the s_ stream is one
// control tick (time, position, validity, fault clear) and produces exactly
// one result on the m_ stream (duty, bridge direction, fault code, moving).
// A request is taken into an input register, evaluated combinationally and
// the result lands in an output register, so the block accepts one request per
// clock cycle while m_tready does not stall it; a result passes the input and
// then the output register. The two registers let a new request enter while a
// result is still waiting. Configuration writes take effect at the write edge
// and are meant to be done while no request is in flight.
module positioner_motor_controller_top
    import pmc_pkg::*;
#(
    parameter int DUTY_BITS = DUTY_BITS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF,
    localparam int S_DATA_BITS = ((TIME_BITS + POS_BITS + 1 + 7) / 8) * 8,
    localparam int M_DATA_BITS = ((DUTY_BITS + 5 + 7) / 8) * 8
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    // Configuration write port.
    input  wire logic                     cfg_wr_en,
    input  wire logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  wire logic [TIME_BITS-1:0]     cfg_wdata,
    // Request stream.
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    // now_ms, position_pct, clear_fault, zero pad
    input  wire logic [S_DATA_BITS-1:0]   s_tdata,
    // position_valid
    input  wire logic                     s_tuser,
    // Result stream.
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    // pwm_duty, drive_forward, drive_reverse, fault_code, moving, zero pad
    output logic      [M_DATA_BITS-1:0]   m_tdata
);

    logic [PCT_BITS-1:0]      target_pct;
    logic [PCT_BITS-1:0]      band_pct;
    logic [DUTY_BITS-1:0]     duty_floor;
    logic [DUTY_BITS-1:0]     hi_duty;
    logic [2*DUTY_BITS+7:0]   duty_weight;
    logic [TIME_BITS-1:0]     move_timeout_ms;

    logic                     in_valid_reg;
    logic [TIME_BITS-1:0]     now_reg;
    logic [POS_BITS-1:0]      pos_reg;
    logic                     pos_valid_reg;
    logic                     clear_reg;

    logic                     out_valid_reg;
    logic [DUTY_BITS-1:0]     out_duty_reg;
    res_flags_t               out_flags_reg;

    logic [DUTY_BITS-1:0]     res_duty;
    res_flags_t               res_flags;
    logic                     advance;

    pmc_cfg #(
        .DUTY_BITS (DUTY_BITS),
        .TIME_BITS (TIME_BITS)
    ) u_cfg (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .target_pct      (target_pct),
        .band_pct        (band_pct),
        .duty_floor      (duty_floor),
        .hi_duty         (hi_duty),
        .duty_weight     (duty_weight),
        .move_timeout_ms (move_timeout_ms)
    );

    pmc_ctrl #(
        .DUTY_BITS (DUTY_BITS),
        .TIME_BITS (TIME_BITS)
    ) u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .step_en         (advance),
        .now_ms          (now_reg),
        .position_pct    (pos_reg),
        .position_valid  (pos_valid_reg),
        .clear_fault     (clear_reg),
        .target_pct      (target_pct),
        .band_pct        (band_pct),
        .duty_floor      (duty_floor),
        .hi_duty         (hi_duty),
        .duty_weight     (duty_weight),
        .move_timeout_ms (move_timeout_ms),
        .res_duty        (res_duty),
        .res_flags       (res_flags)
    );

    // A held request moves on when the output register is free or drains.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            now_reg       <= s_tdata[TIME_BITS-1:0];
            pos_reg       <= s_tdata[TIME_BITS +: POS_BITS];
            clear_reg     <= s_tdata[TIME_BITS+POS_BITS];
            pos_valid_reg <= s_tuser;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_duty_reg  <= res_duty;
            out_flags_reg <= res_flags;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_BITS-DUTY_BITS-5){1'b0}},
                       out_flags_reg.moving,
                       out_flags_reg.fault,
                       out_flags_reg.drive_reverse,
                       out_flags_reg.drive_forward,
                       out_duty_reg};

endmodule

`default_nettype wire

### rtl/pmc_cfg.sv
// Configuration registers and the derived duty limit and duty slope weight.
`default_nettype none

module pmc_cfg
    import pmc_pkg::*;
#(
    parameter int DUTY_BITS = DUTY_BITS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_wr_en,
    input  wire logic [CFG_ADDR_BITS-1:0]   cfg_addr,
    input  wire logic [TIME_BITS-1:0]       cfg_wdata,
    output logic      [PCT_BITS-1:0]        target_pct,
    output logic      [PCT_BITS-1:0]        band_pct,
    output logic      [DUTY_BITS-1:0]       duty_floor,
    output logic      [DUTY_BITS-1:0]       hi_duty,
    output logic      [2*DUTY_BITS+7:0]     duty_weight,
    output logic      [TIME_BITS-1:0]       move_timeout_ms
);

    // Weight = span * ceil(2^SHIFT / 100), so that (mag * weight) >> SHIFT
    // equals floor(mag * span / 100) for every mag below 100.
    localparam int SHIFT        = DUTY_BITS + 14;
    localparam int RECIP_BITS   = SHIFT - 6;
    localparam int WEIGHT_BITS  = DUTY_BITS + RECIP_BITS;
    localparam logic [RECIP_BITS-1:0] RECIP =
        RECIP_BITS'(((64'd1 << SHIFT) + 64'd99) / 64'd100);

    logic [PCT_BITS-1:0]    target_reg,    target_next;
    logic [PCT_BITS-1:0]    dead_band_reg, dead_band_next;
    logic [DUTY_BITS-1:0]   min_reg,       min_next;
    logic [DUTY_BITS-1:0]   max_reg,       max_next;
    logic [DUTY_BITS-1:0]   hi_reg,        hi_next;
    logic [WEIGHT_BITS-1:0] weight_reg,    weight_next;
    logic [TIME_BITS-1:0]   timeout_reg,   timeout_next;
    logic [DUTY_BITS-1:0]   span_next;
    logic [PCT_BITS-1:0]    wr_pct;

    // Register write decode; a target above full scale saturates.
    always_comb begin
        target_next    = target_reg;
        dead_band_next = dead_band_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        timeout_next   = timeout_reg;
        wr_pct         = cfg_wdata[PCT_BITS-1:0];
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_TARGET:    target_next    = (wr_pct > PCT_FULL) ? PCT_FULL : wr_pct;
                CFG_DEAD_BAND: dead_band_next = wr_pct;
                CFG_MIN_DUTY:  min_next       = cfg_wdata[DUTY_BITS-1:0];
                CFG_MAX_DUTY:  max_next       = cfg_wdata[DUTY_BITS-1:0];
                CFG_TIMEOUT:   timeout_next   = cfg_wdata;
                default: ;
            endcase
        end
    end

    // Derived limits follow the new register values in the same edge.
    always_comb begin
        hi_next     = (max_next < min_next) ? min_next : max_next;
        span_next   = hi_next - min_next;
        weight_next = {{RECIP_BITS{1'b0}}, span_next} * {{DUTY_BITS{1'b0}}, RECIP};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg    <= TARGET_RESET;
            dead_band_reg <= DEAD_BAND_RESET;
            min_reg       <= DUTY_BITS'(MIN_DUTY_RESET);
            max_reg       <= DUTY_BITS'(MAX_DUTY_RESET);
            hi_reg        <= DUTY_BITS'(MAX_DUTY_RESET);
            weight_reg    <= WEIGHT_BITS'(DUTY_BITS'(MAX_DUTY_RESET)
                                          - DUTY_BITS'(MIN_DUTY_RESET))
                             * WEIGHT_BITS'(RECIP);
            timeout_reg   <= TIME_BITS'(TIMEOUT_RESET);
        end else begin
            target_reg    <= target_next;
            dead_band_reg <= dead_band_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            hi_reg        <= hi_next;
            weight_reg    <= weight_next;
            timeout_reg   <= timeout_next;
        end
    end

    assign target_pct      = target_reg;
    assign band_pct        = dead_band_reg;
    assign duty_floor      = min_reg;
    assign hi_duty         = hi_reg;
    assign duty_weight     = weight_reg;
    assign move_timeout_ms = timeout_reg;

endmodule

`default_nettype wire

### rtl/pmc_duty.sv
// Proportional duty: min + |err| * span / 100, saturating at the upper limit.
`default_nettype none

module pmc_duty
    import pmc_pkg::*;
#(
    parameter int DUTY_BITS = DUTY_BITS_DEF
) (
    input  wire logic [POS_BITS-1:0]    err_mag,
    input  wire logic [DUTY_BITS-1:0]   duty_floor,
    input  wire logic [DUTY_BITS-1:0]   hi_duty,
    input  wire logic [2*DUTY_BITS+7:0] duty_weight,
    output logic      [DUTY_BITS-1:0]   duty
);

    localparam int SHIFT       = DUTY_BITS + 14;
    localparam int WEIGHT_BITS = 2*DUTY_BITS + 8;
    localparam int PROD_BITS   = WEIGHT_BITS + PCT_BITS;

    logic [PROD_BITS-1:0]  prod;
    logic [DUTY_BITS-1:0]  quot;

    // An error of full scale or more already reaches the upper limit,
    // so the scaled part only handles errors below 100.
    always_comb begin
        prod = PROD_BITS'(err_mag[PCT_BITS-1:0]) * PROD_BITS'(duty_weight);
        quot = prod[SHIFT +: DUTY_BITS];
        if (err_mag >= POS_BITS'(PCT_FULL)) begin
            duty = hi_duty;
        end else begin
            duty = duty_floor + quot;
        end
    end

endmodule

`default_nettype wire

### rtl/pmc_ctrl.sv
// Move state, fault latch and held bridge outputs, updated once per request.
`default_nettype none

module pmc_ctrl
    import pmc_pkg::*;
#(
    parameter int DUTY_BITS = DUTY_BITS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     step_en,
    input  wire logic [TIME_BITS-1:0]     now_ms,
    input  wire logic [POS_BITS-1:0]      position_pct,
    input  wire logic                     position_valid,
    input  wire logic                     clear_fault,
    input  wire logic [PCT_BITS-1:0]      target_pct,
    input  wire logic [PCT_BITS-1:0]      band_pct,
    input  wire logic [DUTY_BITS-1:0]     duty_floor,
    input  wire logic [DUTY_BITS-1:0]     hi_duty,
    input  wire logic [2*DUTY_BITS+7:0]   duty_weight,
    input  wire logic [TIME_BITS-1:0]     move_timeout_ms,
    output logic      [DUTY_BITS-1:0]     res_duty,
    output res_flags_t                    res_flags
);

    logic                   active_reg,  active_next;
    dir_t                   dir_reg,     dir_next;
    logic [PCT_BITS-1:0]    latched_reg, latched_next;
    logic [TIME_BITS-1:0]   start_reg,   start_next;
    fault_t                 fault_reg,   fault_next;
    logic [DUTY_BITS-1:0]   duty_reg,    duty_next;
    logic                   fwd_reg,     fwd_next;
    logic                   rev_reg,     rev_next;

    logic signed [POS_BITS:0] cur;
    logic signed [POS_BITS:0] tgt;
    logic signed [POS_BITS:0] lt;
    logic signed [POS_BITS:0] gap;
    logic signed [POS_BITS:0] err;
    logic [POS_BITS-1:0]      gap_mag;
    logic [POS_BITS-1:0]      err_mag;
    logic [PCT_BITS-1:0]      move_tgt;
    logic [TIME_BITS-1:0]     move_t0;
    logic [DUTY_BITS-1:0]     prop_duty;
    logic [TIME_BITS-1:0]     elapsed;
    logic                     reached;
    logic                     in_band;

    pmc_duty #(
        .DUTY_BITS (DUTY_BITS)
    ) u_duty (
        .err_mag     (err_mag),
        .duty_floor  (duty_floor),
        .hi_duty     (hi_duty),
        .duty_weight (duty_weight),
        .duty        (prop_duty)
    );

    // Distance to the setpoint, used to decide whether a move starts.
    always_comb begin
        cur     = {position_pct[POS_BITS-1], position_pct};
        tgt     = $signed({{(POS_BITS+1-PCT_BITS){1'b0}}, target_pct});
        gap     = cur - tgt;
        gap_mag = gap[POS_BITS] ? POS_BITS'(-gap) : gap[POS_BITS-1:0];
        in_band = gap_mag <= POS_BITS'(band_pct);
    end

    // Error against the target of the move that is (or is now) active.
    // An idle controller that starts a move latches the setpoint and the time.
    always_comb begin
        move_tgt = active_reg ? latched_reg : target_pct;
        move_t0  = active_reg ? start_reg : now_ms;
        lt       = $signed({{(POS_BITS+1-PCT_BITS){1'b0}}, move_tgt});
        err      = lt - cur;
        err_mag  = err[POS_BITS] ? POS_BITS'(-err) : err[POS_BITS-1:0];
        elapsed  = now_ms - move_t0;
    end

    // Next state for one control tick.
    always_comb begin
        active_next  = active_reg;
        dir_next     = dir_reg;
        latched_next = latched_reg;
        start_next   = start_reg;
        fault_next   = clear_fault ? FAULT_NONE : fault_reg;
        duty_next    = duty_reg;
        fwd_next     = fwd_reg;
        rev_next     = rev_reg;
        reached      = 1'b0;

        if (fault_next == FAULT_TIMEOUT || !position_valid) begin
            // A latched timeout or a bad reading stops the bridge.
            if (fault_next != FAULT_TIMEOUT) begin
                fault_next = FAULT_FEEDBACK;
            end
            active_next = 1'b0;
            dir_next    = DIR_NONE;
            duty_next   = '0;
            fwd_next    = 1'b0;
            rev_next    = 1'b0;
        end else if (!active_reg && in_band) begin
            // Idle inside the dead band: the held outputs repeat.
        end else begin
            if (!active_reg) begin
                latched_next = target_pct;
                dir_next     = (tgt > cur) ? DIR_UP : ((tgt < cur) ? DIR_DOWN : DIR_NONE);
                active_next  = 1'b1;
                start_next   = now_ms;
            end

            case (dir_next)
                DIR_UP:   reached = (cur >= lt);
                DIR_DOWN: reached = (cur <= lt);
                default:  reached = 1'b1;
            endcase

            if (reached) begin
                active_next = 1'b0;
                dir_next    = DIR_NONE;
                duty_next   = '0;
                fwd_next    = 1'b0;
                rev_next    = 1'b0;
            end else if (elapsed > move_timeout_ms) begin
                // Overlong move: stop and latch the timeout.
                active_next = 1'b0;
                dir_next    = DIR_NONE;
                duty_next   = '0;
                fwd_next    = 1'b0;
                rev_next    = 1'b0;
                fault_next  = FAULT_TIMEOUT;
            end else begin
                duty_next = prop_duty;
                fwd_next  = (err > 0);
                rev_next  = !(err > 0);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            dir_reg     <= DIR_NONE;
            latched_reg <= TARGET_RESET;
            start_reg   <= '0;
            fault_reg   <= FAULT_NONE;
            duty_reg    <= '0;
            fwd_reg     <= 1'b0;
            rev_reg     <= 1'b0;
        end else if (step_en) begin
            active_reg  <= active_next;
            dir_reg     <= dir_next;
            latched_reg <= latched_next;
            start_reg   <= start_next;
            fault_reg   <= fault_next;
            duty_reg    <= duty_next;
            fwd_reg     <= fwd_next;
            rev_reg     <= rev_next;
        end
    end

    // The result of a tick is the state it leaves behind.
    always_comb begin
        res_duty                = duty_next;
        res_flags.drive_forward = fwd_next;
        res_flags.drive_reverse = rev_next;
        res_flags.fault         = fault_next;
        res_flags.moving        = active_next;
    end

endmodule

`default_nettype wire

### rtl/pmc_checker.sv
// Port-level checks of the positioner motor controller and their binding.
`default_nettype none

module pmc_checker
    import pmc_pkg::*;
#(
    parameter int DUTY_BITS   = DUTY_BITS_DEF,
    parameter int M_DATA_BITS = 16
) (
    input wire logic                   aclk,
    input wire logic                   aresetn,
    input wire logic                   m_tvalid,
    input wire logic                   m_tready,
    input wire logic [M_DATA_BITS-1:0] m_tdata
);

    logic [DUTY_BITS-1:0] duty;
    logic                 fwd;
    logic                 rev;
    logic [1:0]           fault;
    logic                 moving;

    assign duty   = m_tdata[DUTY_BITS-1:0];
    assign fwd    = m_tdata[DUTY_BITS];
    assign rev    = m_tdata[DUTY_BITS+1];
    assign fault  = m_tdata[DUTY_BITS+3:DUTY_BITS+2];
    assign moving = m_tdata[DUTY_BITS+4];

    // A stalled result stays offered and unchanged.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Reset empties the output register.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result offered right after reset");

    // A timeout fault always leaves the bridge off and the move ended.
    a_timeout_off: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && fault == FAULT_TIMEOUT |-> duty == '0 && !fwd && !rev && !moving)
        else $error("bridge driven under timeout fault");

    // While moving, exactly one bridge input is driven.
    a_moving_dir: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && moving |-> fwd != rev)
        else $error("moving without a single drive direction");

    // Both bridge inputs are never high together.
    a_no_shoot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(fwd && rev))
        else $error("both bridge inputs high");

endmodule

bind positioner_motor_controller_top pmc_checker #(
    .DUTY_BITS   (DUTY_BITS),
    .M_DATA_BITS (M_DATA_BITS)
) u_pmc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

### tb/tb_positioner_motor_controller_top.sv
// Self-checking testbench of the positioner motor controller: directed and random control ticks.
module tb_positioner_motor_controller_top;
    timeunit 1ns;
    timeprecision 1ps;
    import pmc_pkg::*;

    localparam int S_W = ((TIME_BITS_DEF + POS_BITS + 1 + 7) / 8) * 8;
    localparam int M_W = ((DUTY_BITS_DEF + 5 + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASES = 12;
    localparam int TICKS_PER_PHASE = 135;
    // First register index past the end of the list; such writes are ignored.
    localparam logic [CFG_ADDR_BITS-1:0] CFG_UNUSED_FIRST = CFG_ADDR_BITS'(CFG_TIMEOUT + 1);

    // One control tick as sent on the request stream.
    typedef struct {
        logic [31:0]       now;
        logic signed [9:0] pos;
        logic              valid;
        logic              clr;
    } tick_t;

    // One result, laid out as on m_tdata from bit 0 up.
    typedef struct packed {
        logic       moving;
        fault_t     fault;
        logic       rev;
        logic       fwd;
        logic [9:0] duty;
    } ctl_result_t;

    logic                     aclk;
    logic                     aresetn;
    logic                     cfg_wr_en;
    logic [CFG_ADDR_BITS-1:0] cfg_addr;
    logic [31:0]              cfg_wdata;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [S_W-1:0]           s_tdata;
    logic                     s_tuser;
    logic                     m_tvalid;
    logic                     m_tready;
    logic [M_W-1:0]           m_tdata;

    positioner_motor_controller_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Controller settings as the testbench believes them to be.
    logic [6:0]  set_target;
    logic [6:0]  set_dead_band;
    logic [9:0]  set_duty_floor;
    logic [9:0]  set_max_duty;
    logic [31:0] set_timeout;

    // Controller state mirrored by the predictor.
    logic        mv_active;
    dir_t        mv_dir;
    logic [6:0]  mv_target;
    logic [31:0] mv_start;
    fault_t      flt;
    logic [9:0]  hold_duty;
    logic        hold_fwd;
    logic        hold_rev;

    ctl_result_t pending_results[$];
    ctl_result_t exp_res;
    ctl_result_t got_res;
    int          mismatches;
    int          cycles;

    // Idling control: odds of a burst (0 means none), and a flag for the idle-free tail.
    int          idle_odds;
    logic        quiet;
    int          stall_left;

    // Plant model used to shape well-formed position sequences.
    int          plant_pos;
    logic [31:0] plant_time;
    int          max_dt;

    // Clock.
    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Run guard.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Apply a register write to the predictor's settings.
    task automatic apply_setting(input logic [CFG_ADDR_BITS-1:0] idx, input logic [31:0] val);
        case (idx)
            CFG_TARGET:    set_target = (val[6:0] > PCT_FULL) ? PCT_FULL : val[6:0];
            CFG_DEAD_BAND: set_dead_band = val[6:0];
            CFG_MIN_DUTY:  set_duty_floor = val[9:0];
            CFG_MAX_DUTY:  set_max_duty = val[9:0];
            CFG_TIMEOUT:   set_timeout = val;
            default: ;
        endcase
    endtask

    task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = val;
        @(posedge aclk);
        apply_setting(idx, val);
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    // Stop the bridge and leave the move.
    task automatic stop_move();
        hold_duty = '0;
        hold_fwd  = 1'b0;
        hold_rev  = 1'b0;
        mv_active = 1'b0;
        mv_dir    = DIR_NONE;
    endtask

    // Work out the result of one accepted tick and queue it.
    task automatic predict_tick(input tick_t tk);
        int          cur;
        int          dev;
        int          mag;
        int          lo;
        int          hi;
        int          duty;
        logic        run;
        logic        reached;
        ctl_result_t r;
        cur = int'(tk.pos);
        run = 1'b1;
        if (tk.clr)
            flt = FAULT_NONE;
        if (flt == FAULT_TIMEOUT) begin
            stop_move();
        end else if (!tk.valid) begin
            flt = FAULT_FEEDBACK;
            stop_move();
        end else begin
            // An idle controller starts a move only outside the dead band.
            if (!mv_active) begin
                dev = cur - int'(set_target);
                if (dev < 0)
                    dev = -dev;
                if (dev <= int'(set_dead_band)) begin
                    run = 1'b0;
                end else begin
                    mv_target = set_target;
                    if (int'(set_target) > cur)
                        mv_dir = DIR_UP;
                    else if (int'(set_target) < cur)
                        mv_dir = DIR_DOWN;
                    else
                        mv_dir = DIR_NONE;
                    mv_active = 1'b1;
                    mv_start  = tk.now;
                end
            end
            if (run) begin
                reached = (mv_dir == DIR_UP && cur >= int'(mv_target)) ||
                          (mv_dir == DIR_DOWN && cur <= int'(mv_target)) ||
                          (mv_dir != DIR_UP && mv_dir != DIR_DOWN);
                if (reached) begin
                    stop_move();
                end else begin
                    // Proportional duty between the two limits.
                    mag = int'(mv_target) - cur;
                    if (mag < 0)
                        mag = -mag;
                    lo = int'(set_duty_floor);
                    hi = (set_max_duty < set_duty_floor) ? lo : int'(set_max_duty);
                    duty = mag * (hi - lo) / 100 + lo;
                    if (duty > hi)
                        duty = hi;
                    hold_duty = duty[9:0];
                    hold_fwd  = (int'(mv_target) - cur) > 0;
                    hold_rev  = !hold_fwd;
                    if ((tk.now - mv_start) > set_timeout) begin
                        stop_move();
                        flt = FAULT_TIMEOUT;
                    end
                end
            end
        end
        r.duty   = hold_duty;
        r.fwd    = hold_fwd;
        r.rev    = hold_rev;
        r.fault  = flt;
        r.moving = mv_active;
        pending_results.push_back(r);
    endtask

    // Send one tick, with a random gap before it, and predict its result once accepted.
    task automatic send_tick(input tick_t tk);
        int gap;
        gap = 0;
        if (!quiet && idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0)
            gap = $urandom_range(1, 17);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata        = '0;
        s_tdata[31:0]  = tk.now;
        s_tdata[41:32] = tk.pos;
        s_tdata[42]    = tk.clr;
        s_tuser        = tk.valid;
        s_tvalid       = 1'b1;
        do @(posedge aclk); while (!s_tready);
        predict_tick(tk);
    endtask

    task automatic tick(input logic [31:0] now, input int pos, input logic valid,
                        input logic clr);
        tick_t tk;
        tk.now   = now;
        tk.pos   = pos[9:0];
        tk.valid = valid;
        tk.clr   = clr;
        send_tick(tk);
    endtask

    // Wait until every queued result has arrived and the pipeline is empty.
    task automatic drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Result checker.
    task automatic report(input string what, input longint want, input longint seen);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on %s: expected %0d, got %0d at %0t", what, want, seen, $realtime);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_res = ctl_result_t'(m_tdata[$bits(ctl_result_t)-1:0]);
            if (pending_results.size() == 0) begin
                report("unexpected result", 0, 1);
            end else begin
                exp_res = pending_results.pop_front();
                if (got_res.duty !== exp_res.duty)
                    report("pwm_duty", exp_res.duty, got_res.duty);
                if (got_res.fwd !== exp_res.fwd)
                    report("drive_forward", exp_res.fwd, got_res.fwd);
                if (got_res.rev !== exp_res.rev)
                    report("drive_reverse", exp_res.rev, got_res.rev);
                if (got_res.fault !== exp_res.fault)
                    report("fault_code", exp_res.fault, got_res.fault);
                if (got_res.moving !== exp_res.moving)
                    report("moving", exp_res.moving, got_res.moving);
            end
        end
    end

    // Result-side back-pressure in random bursts.
    always @(negedge aclk) begin
        if (!aresetn || quiet || idle_odds == 0) begin
            m_tready = 1'b1;
        end else if (stall_left > 0) begin
            m_tready   = 1'b0;
            stall_left = stall_left - 1;
        end else if ($urandom_range(0, idle_odds - 1) == 0) begin
            m_tready   = 1'b0;
            stall_left = $urandom_range(1, 17) - 1;
        end else begin
            m_tready = 1'b1;
        end
    end

    // Reset defaults, dead band edges, faults, timeout and clamping at full error.
    task automatic test_reset_defaults();
        tick(32'd0, 25, 1'b1, 1'b0);
        tick(32'd50, 27, 1'b1, 1'b0);
        tick(32'd100, 28, 1'b1, 1'b0);
        tick(32'd200, 26, 1'b1, 1'b0);
        tick(32'd250, 25, 1'b1, 1'b0);
        tick(32'd300, 0, 1'b1, 1'b0);
        tick(32'd400, 0, 1'b0, 1'b0);
        tick(32'd500, 0, 1'b1, 1'b0);
        tick(32'd10501, 0, 1'b1, 1'b0);
        tick(32'd10600, 0, 1'b1, 1'b0);
        tick(32'd10700, -512, 1'b1, 1'b1);
        tick(32'd10800, 511, 1'b1, 1'b0);
        tick(32'd10900, 511, 1'b1, 1'b0);
        tick(32'd11000, 24, 1'b1, 1'b1);
        drain();
    endtask

    // Register extremes: saturated target, inverted duty limits, zero and full timeouts,
    // time wrap and ignored indexes.
    task automatic test_register_extremes();
        write_reg(CFG_TARGET, 32'hFFFF_FFFF);
        write_reg(CFG_DEAD_BAND, 32'd0);
        write_reg(CFG_MIN_DUTY, 32'h0000_03FF);
        write_reg(CFG_MAX_DUTY, 32'd0);
        write_reg(CFG_TIMEOUT, 32'd0);
        write_reg(CFG_UNUSED_FIRST, 32'hFFFF_FFFF);
        write_reg(CFG_ADDR_BITS'(CFG_UNUSED_FIRST + 1), 32'h1234_5678);
        write_reg(CFG_ADDR_BITS'(CFG_UNUSED_FIRST + 2), 32'hFFFF_FFFF);
        tick(32'hFFFF_FFFF, 99, 1'b1, 1'b0);
        tick(32'd0, 99, 1'b1, 1'b0);
        tick(32'd1, 100, 1'b1, 1'b1);
        drain();
        write_reg(CFG_TARGET, 32'd0);
        write_reg(CFG_DEAD_BAND, 32'h7F);
        write_reg(CFG_MIN_DUTY, 32'd0);
        write_reg(CFG_MAX_DUTY, 32'hFFFF_FC00 | 32'h3FF);
        write_reg(CFG_TIMEOUT, 32'd10);
        tick(32'hFFFF_FFF0, 127, 1'b1, 1'b0);
        tick(32'hFFFF_FFFA, 128, 1'b1, 1'b0);
        tick(32'd5, 60, 1'b1, 1'b0);
        tick(32'd6, 60, 1'b1, 1'b1);
        drain();
        write_reg(CFG_TIMEOUT, 32'hFFFF_FFFF);
        tick(32'h8000_0000, -300, 1'b1, 1'b0);
        tick(32'h7FFF_FFFF, 200, 1'b1, 1'b0);
        tick(32'h0000_0000, -1, 1'b1, 1'b0);
        drain();
    endtask

    // Pick new settings for a random phase, the extremes among them.
    task automatic choose_settings();
        int pick;
        pick = $urandom_range(0, 5);
        write_reg(CFG_TARGET, pick == 0 ? 32'd0 : pick == 1 ? 32'd100 :
                  pick == 2 ? $urandom : $urandom_range(0, 100));
        pick = $urandom_range(0, 7);
        write_reg(CFG_DEAD_BAND, pick == 0 ? 32'd0 : pick == 1 ? $urandom :
                  $urandom_range(0, 8));
        pick = $urandom_range(0, 5);
        write_reg(CFG_MIN_DUTY, pick == 0 ? 32'd0 : pick == 1 ? 32'h3FF : $urandom);
        pick = $urandom_range(0, 5);
        write_reg(CFG_MAX_DUTY, pick == 0 ? 32'd0 : pick == 1 ? 32'h3FF : $urandom);
        pick = $urandom_range(0, 5);
        write_reg(CFG_TIMEOUT, pick == 0 ? 32'd0 : pick == 1 ? 32'hFFFF_FFFF :
                  pick == 2 ? $urandom : $urandom_range(1, 120));
        if ($urandom_range(0, 3) == 0)
            write_reg(CFG_ADDR_BITS'($urandom_range(CFG_UNUSED_FIRST, CFG_UNUSED_FIRST + 2)),
                      $urandom);
    endtask

    // Random phases: mostly plant-like sequences with random content, some noise.
    task automatic test_random_moves();
        tick_t tk;
        int    step;
        for (int ph = 0; ph < PHASES; ph++) begin
            choose_settings();
            case ($urandom_range(0, 3))
                0: idle_odds = 0;
                1: idle_odds = 2;
                2: idle_odds = 5;
                default: idle_odds = 12;
            endcase
            quiet = (ph == PHASES - 1);
            max_dt = $urandom_range(0, 3) == 0 ? 2000 : $urandom_range(1, 20);
            if ($urandom_range(0, 2) == 0)
                plant_time = 32'hFFFF_FFFF - $urandom_range(0, 600);
            plant_pos = $urandom_range(0, 100);
            for (int n = 0; n < TICKS_PER_PHASE; n++) begin
                if ($urandom_range(0, 9) == 0) begin
                    tk.now     = $urandom;
                    tk.pos     = 10'($urandom);
                    tk.valid   = 1'($urandom);
                    tk.clr     = 1'($urandom);
                    plant_time = tk.now;
                end else begin
                    plant_time = plant_time + $urandom_range(0, max_dt);
                    step = $urandom_range(0, 8);
                    if (hold_fwd)
                        plant_pos = plant_pos + step;
                    else if (hold_rev)
                        plant_pos = plant_pos - step;
                    else if ($urandom_range(0, 9) == 0)
                        plant_pos = $urandom_range(0, 100);
                    else if ($urandom_range(0, 40) == 0)
                        plant_pos = $urandom_range(0, 1023) - 512;
                    else
                        plant_pos = plant_pos + $urandom_range(0, 2) - 1;
                    if (plant_pos > 511)
                        plant_pos = 511;
                    if (plant_pos < -512)
                        plant_pos = -512;
                    tk.now   = plant_time;
                    tk.pos   = plant_pos[9:0];
                    tk.valid = $urandom_range(0, 30) != 0;
                    tk.clr   = (flt != FAULT_NONE) ? ($urandom_range(0, 5) == 0)
                                                   : ($urandom_range(0, 19) == 0);
                end
                send_tick(tk);
            end
            drain();
        end
    endtask

    // Stimulus sequence.
    initial begin
        aresetn    = 1'b0;
        cfg_wr_en  = 1'b0;
        cfg_addr   = '0;
        cfg_wdata  = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = 1'b0;
        m_tready   = 1'b0;
        mismatches = 0;
        cycles     = 0;
        idle_odds  = 0;
        quiet      = 1'b0;
        stall_left = 0;
        plant_time = 32'd0;
        plant_pos  = 25;
        max_dt     = 10;

        // Predictor reset state.
        set_target     = TARGET_RESET;
        set_dead_band  = DEAD_BAND_RESET;
        set_duty_floor = 10'(MIN_DUTY_RESET);
        set_max_duty   = 10'(MAX_DUTY_RESET);
        set_timeout    = TIMEOUT_RESET;
        mv_target      = TARGET_RESET;
        mv_start       = '0;
        flt            = FAULT_NONE;
        stop_move();

        repeat (12) @(negedge aclk);
        aresetn = 1'b1;
        repeat (2) @(negedge aclk);

        idle_odds = 4;
        test_reset_defaults();
        test_register_extremes();
        test_random_moves();

        drain();
        repeat (10) @(posedge aclk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
